/* rtl/dcf_pkg.sv */
// Shared types and constants of the directed cycle finder.
package dcf_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 4096;
   localparam int FIELD_W       = 11;
   localparam logic [FIELD_W-1:0] NODE_COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   typedef struct packed {
      op_type             operation;
      logic [FIELD_W-1:0] edge_from;
      logic [FIELD_W-1:0] edge_to;
      logic [FIELD_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] cycle_length;
      logic [FIELD_W-1:0] vertex;
   } rsp_type;

endpackage

/* rtl/directed_cycle_finder_core.sv */
// Directed cycle finder: edge lists, depth-first search and cycle store in memories.
// Add edge answers at once if rejected, else writes the edge and, if the list is not empty, links it
// behind its tail; read fetches from the cycle memory; clear sweeps the list memory. Run clears the colors
// of the n nodes, then searches from each root along the edges; building the cycle walks the parent memory.
// A result is shown for one cycle on rsp_valid; the receiver cannot stall it.
// After reset the block is busy while the list memory is swept.
module directed_cycle_finder_core #(
   parameter int MAX_NODES = dcf_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = dcf_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  dcf_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output dcf_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [dcf_pkg::FIELD_W-1:0]     csr_wdata
);

   localparam int FW  = dcf_pkg::FIELD_W;
   localparam int VW  = $clog2(MAX_NODES + 1);
   localparam int CW  = VW + 1;
   localparam int ZW  = VW + 2;
   localparam int CAW = $clog2(MAX_NODES + 2);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   typedef enum logic [15:0] {
      S_IDLE    = 16'h0001,
      S_INIT    = 16'h0002,
      S_ADD_WR  = 16'h0004,
      S_ADD_LNK = 16'h0008,
      S_CLR_COL = 16'h0010,
      S_ROOT_RD = 16'h0020,
      S_ROOT_CK = 16'h0040,
      S_STEP    = 16'h0080,
      S_POP     = 16'h0100,
      S_EDGE    = 16'h0200,
      S_COL     = 16'h0400,
      S_CNT     = 16'h0800,
      S_CNT_W   = 16'h1000,
      S_WR      = 16'h2000,
      S_WR_W    = 16'h4000,
      S_RD_WAIT = 16'h8000
   } state_type;

   typedef struct packed {
      logic [EW-1:0] head;
      logic [EW-1:0] tail;
   } list_type;

   typedef struct packed {
      logic [VW-1:0] node;
      logic [EW-1:0] edge_ref;
   } frame_type;

   state_type         state_ff, state_in;
   logic [FW-1:0]     ncfg_ff;
   dcf_pkg::req_type  req_ff, req_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [EW-1:0]     total_ff, total_in;
   logic [ZW-1:0]     size_ff, size_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [EW-1:0]     tail_ff, tail_in;
   logic [VW-1:0]     top_v_ff, top_v_in;
   logic [EW-1:0]     top_e_ff, top_e_in;
   logic [CW-1:0]     depth_ff, depth_in;
   logic [VW-1:0]     x_ff, x_in;
   logic [VW-1:0]     hit_ff, hit_in;
   logic [VW-1:0]     closer_ff, closer_in;
   logic [VW-1:0]     v_ff, v_in;
   logic [CW-1:0]     chain_ff, chain_in;
   logic [CW-1:0]     i_ff, i_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dcf_pkg::rsp_type  rsp_ff, rsp_in;
   logic [VW-1:0]     n_w;

   list_type          list_mem [MAX_NODES+1];
   list_type          list_rd_ff;
   logic              list_we;
   logic [VW-1:0]     list_wa, list_ra;
   list_type          list_wd;

   logic [FW-1:0]     tgt_mem [MAX_EDGES];
   logic [FW-1:0]     tgt_rd_ff;
   logic              tgt_we;
   logic [EAW-1:0]    tgt_wa;

   logic [EW-1:0]     link_mem [MAX_EDGES];
   logic [EW-1:0]     link_rd_ff;
   logic              link_we;
   logic [EAW-1:0]    link_wa, edge_ra;
   logic [EW-1:0]     link_wd;

   logic [1:0]        col_mem [MAX_NODES+1];
   logic [1:0]        col_rd_ff;
   logic              col_we;
   logic [VW-1:0]     col_wa, col_ra;
   logic [1:0]        col_wd;

   logic [VW-1:0]     par_mem [MAX_NODES+1];
   logic [VW-1:0]     par_rd_ff;
   logic              par_we;
   logic [VW-1:0]     par_wa, par_ra;

   frame_type         stk_mem [MAX_NODES+1];
   frame_type         stk_rd_ff;
   logic              stk_we;
   logic [VW-1:0]     stk_wa, stk_ra;
   frame_type         stk_wd;

   logic [VW-1:0]     cyc_mem [MAX_NODES+2];
   logic [VW-1:0]     cyc_rd_ff;
   logic              cyc_we;
   logic [CAW-1:0]    cyc_wa, cyc_ra;
   logic [VW-1:0]     cyc_wd;

   always_comb begin
      if (32'(ncfg_ff) > MAX_NODES) begin
         n_w = VW'(MAX_NODES);
      end else begin
         n_w = VW'(ncfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      list_rd_ff <= list_mem[list_ra];
   end

   always_ff @(posedge clock) begin
      if (tgt_we) begin
         tgt_mem[tgt_wa] <= req_ff.edge_to;
      end
      tgt_rd_ff <= tgt_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[edge_ra];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_wa] <= col_wd;
      end
      col_rd_ff <= col_mem[col_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= top_v_ff;
      end
      par_rd_ff <= par_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_rd_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (cyc_we) begin
         cyc_mem[cyc_wa] <= cyc_wd;
      end
      cyc_rd_ff <= cyc_mem[cyc_ra];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      size_in      = size_ff;
      clr_rsp_in   = clr_rsp_ff;
      tail_in      = tail_ff;
      top_v_in     = top_v_ff;
      top_e_in     = top_e_ff;
      depth_in     = depth_ff;
      x_in         = x_ff;
      hit_in       = hit_ff;
      closer_in    = closer_ff;
      v_in         = v_ff;
      chain_in     = chain_ff;
      i_in         = i_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      list_we = 1'b0;
      list_wa = VW'(req_ff.edge_from);
      list_wd = '0;
      list_ra = VW'(req_data.edge_from);
      tgt_we  = 1'b0;
      tgt_wa  = EAW'(total_ff);
      link_we = 1'b0;
      link_wa = EAW'(total_ff);
      link_wd = '0;
      edge_ra = EAW'(top_e_ff - EW'(1));
      col_we  = 1'b0;
      col_wa  = top_v_ff;
      col_wd  = 2'd0;
      col_ra  = VW'(cnt_ff);
      par_we  = 1'b0;
      par_wa  = x_ff;
      par_ra  = v_ff;
      stk_we  = 1'b0;
      stk_wa  = VW'(depth_ff - CW'(1));
      stk_wd  = '{node: top_v_ff, edge_ref: top_e_ff};
      stk_ra  = VW'(depth_ff - CW'(2));
      cyc_we  = 1'b0;
      cyc_wa  = '0;
      cyc_wd  = hit_ff;
      cyc_ra  = CAW'(req_data.read_index);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               unique case (req_data.operation)
                  dcf_pkg::OP_ADD: begin
                     if (req_data.edge_from == '0 || 32'(req_data.edge_from) > 32'(n_w) ||
                         req_data.edge_to == '0 || 32'(req_data.edge_to) > 32'(n_w)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{dcf_pkg::ST_BAD, FW'(size_ff), '0};
                     end else if (32'(total_ff) >= MAX_EDGES) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{dcf_pkg::ST_FULL, FW'(size_ff), '0};
                     end else begin
                        state_in = S_ADD_WR;
                     end
                  end
                  dcf_pkg::OP_RUN: begin
                     size_in  = '0;
                     cnt_in   = CW'(1);
                     state_in = S_CLR_COL;
                  end
                  dcf_pkg::OP_READ: begin
                     if (size_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{dcf_pkg::ST_NONE, '0, '0};
                     end else if (32'(req_data.read_index) >= 32'(size_ff) ||
                                  32'(req_data.read_index) > MAX_NODES) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{dcf_pkg::ST_BAD, FW'(size_ff), '0};
                     end else begin
                        state_in = S_RD_WAIT;
                     end
                  end
                  dcf_pkg::OP_CLEAR: begin
                     total_in   = '0;
                     cnt_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_INIT;
                  end
               endcase
            end
         end
         S_INIT: begin
            list_we = 1'b1;
            list_wa = VW'(cnt_ff);
            list_wd = '0;
            if (cnt_ff == CW'(MAX_NODES)) begin
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{dcf_pkg::ST_OK, FW'(size_ff), '0};
               end
               clr_rsp_in = 1'b0;
               state_in   = S_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_ADD_WR: begin
            tgt_we   = 1'b1;
            link_we  = 1'b1;
            list_we  = 1'b1;
            list_wd.tail = total_ff + EW'(1);
            list_wd.head = (list_rd_ff.tail == '0) ? total_ff + EW'(1) : list_rd_ff.head;
            total_in = total_ff + EW'(1);
            tail_in  = list_rd_ff.tail;
            if (list_rd_ff.tail == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{dcf_pkg::ST_OK, FW'(size_ff), '0};
               state_in = S_IDLE;
            end else begin
               state_in = S_ADD_LNK;
            end
         end
         S_ADD_LNK: begin
            link_we = 1'b1;
            link_wa = EAW'(tail_ff - EW'(1));
            link_wd = total_ff;
            rsp_valid_in = 1'b1;
            rsp_in = '{dcf_pkg::ST_OK, FW'(size_ff), '0};
            state_in = S_IDLE;
         end
         S_CLR_COL: begin
            if (cnt_ff <= CW'(n_w)) begin
               col_we = 1'b1;
               col_wa = VW'(cnt_ff);
               col_wd = 2'd0;
               cnt_in = cnt_ff + CW'(1);
            end else begin
               cnt_in   = CW'(1);
               state_in = S_ROOT_RD;
            end
         end
         S_ROOT_RD: begin
            col_ra  = VW'(cnt_ff);
            list_ra = VW'(cnt_ff);
            if (cnt_ff > CW'(n_w)) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{dcf_pkg::ST_NONE, '0, '0};
               state_in = S_IDLE;
            end else begin
               state_in = S_ROOT_CK;
            end
         end
         S_ROOT_CK: begin
            if (col_rd_ff == 2'd0) begin
               col_we   = 1'b1;
               col_wa   = VW'(cnt_ff);
               col_wd   = 2'd1;
               top_v_in = VW'(cnt_ff);
               top_e_in = list_rd_ff.head;
               depth_in = CW'(1);
               state_in = S_STEP;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_ROOT_RD;
            end
         end
         S_STEP: begin
            if (top_e_ff == '0 || 32'(top_e_ff) > MAX_EDGES) begin
               col_we = 1'b1;
               col_wd = 2'd2;
               if (depth_ff == CW'(1)) begin
                  cnt_in   = cnt_ff + CW'(1);
                  state_in = S_ROOT_RD;
               end else begin
                  depth_in = depth_ff - CW'(1);
                  state_in = S_POP;
               end
            end else begin
               state_in = S_EDGE;
            end
         end
         S_POP: begin
            top_v_in = stk_rd_ff.node;
            top_e_in = stk_rd_ff.edge_ref;
            state_in = S_STEP;
         end
         S_EDGE: begin
            top_e_in = link_rd_ff;
            x_in     = VW'(tgt_rd_ff);
            col_ra   = VW'(tgt_rd_ff);
            list_ra  = VW'(tgt_rd_ff);
            if (tgt_rd_ff == '0 || 32'(tgt_rd_ff) > 32'(n_w)) begin
               state_in = S_STEP;
            end else begin
               state_in = S_COL;
            end
         end
         S_COL: begin
            priority if (col_rd_ff == 2'd0) begin
               if (32'(depth_ff) <= MAX_NODES) begin
                  par_we   = 1'b1;
                  col_we   = 1'b1;
                  col_wa   = x_ff;
                  col_wd   = 2'd1;
                  stk_we   = 1'b1;
                  top_v_in = x_ff;
                  top_e_in = list_rd_ff.head;
                  depth_in = depth_ff + CW'(1);
               end
               state_in = S_STEP;
            end else if (col_rd_ff == 2'd1) begin
               hit_in    = x_ff;
               closer_in = top_v_ff;
               v_in      = top_v_ff;
               chain_in  = '0;
               cyc_we    = 1'b1;
               cyc_wa    = '0;
               cyc_wd    = x_ff;
               state_in  = S_CNT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_CNT: begin
            if (v_ff != hit_ff && chain_ff < CW'(n_w)) begin
               chain_in = chain_ff + CW'(1);
               state_in = S_CNT_W;
            end else begin
               i_in     = chain_ff;
               v_in     = closer_ff;
               state_in = S_WR;
            end
         end
         S_CNT_W: begin
            v_in     = par_rd_ff;
            state_in = S_CNT;
         end
         S_WR: begin
            cyc_we = 1'b1;
            if (i_ff != '0) begin
               cyc_wa   = CAW'(i_ff);
               cyc_wd   = v_ff;
               i_in     = i_ff - CW'(1);
               state_in = S_WR_W;
            end else begin
               cyc_wa   = CAW'(chain_ff + CW'(1));
               cyc_wd   = hit_ff;
               size_in  = ZW'(chain_ff) + ZW'(2);
               rsp_valid_in = 1'b1;
               rsp_in = '{dcf_pkg::ST_OK, FW'(ZW'(chain_ff) + ZW'(2)), '0};
               state_in = S_IDLE;
            end
         end
         S_WR_W: begin
            v_in     = par_rd_ff;
            state_in = S_WR;
         end
         S_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{dcf_pkg::ST_OK, FW'(size_ff), FW'(cyc_rd_ff)};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ncfg_ff      <= dcf_pkg::NODE_COUNT_RESET;
         cnt_ff       <= '0;
         total_ff     <= '0;
         size_ff      <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            ncfg_ff <= csr_wdata;
         end
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         size_ff      <= size_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      tail_ff   <= tail_in;
      top_v_ff  <= top_v_in;
      top_e_ff  <= top_e_in;
      depth_ff  <= depth_in;
      x_ff      <= x_in;
      hit_ff    <= hit_in;
      closer_ff <= closer_in;
      v_ff      <= v_in;
      chain_ff  <= chain_in;
      i_ff      <= i_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/dcf_checker.sv */
// Port-level checks of the directed cycle finder and their binding.
module dcf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input dcf_pkg::rsp_type            rsp_data
);

   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("Block is not busy after reset.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("Accepted beat neither answered nor worked on.");

   a_none_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == dcf_pkg::ST_NONE) |-> (rsp_data.cycle_length == '0))
      else $error("No-cycle result carries a nonzero length.");

   a_vertex_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.vertex != '0) |-> (rsp_data.status == dcf_pkg::ST_OK))
      else $error("Vertex reported on an unsuccessful result.");

endmodule

bind directed_cycle_finder_core dcf_checker u_dcf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
